// ===== hdl/fbpa_pkg.sv =====
package fbpa_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ADDR_W = 32;
  localparam int SIZE_W = 16;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_BELOW = 3'd3;
  localparam logic [2:0] ST_BEYOND = 3'd4;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic CFG_BLOCK_SIZE = 1'b0;
  localparam logic CFG_POOL_BASE = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_DIV
  } state_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } mdu_op_t;

  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_req_t;

endpackage

// ===== hdl/fbpa_mdu.sv =====
module fbpa_mdu (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fbpa_pkg::mdu_req_t            req,
  input  logic [fbpa_pkg::ADDR_W-1:0]   opa,
  input  logic [fbpa_pkg::SIZE_W-1:0]   opb,
  input  logic [fbpa_pkg::IDX_W-1:0]    idx,
  output logic                          done,
  output logic [fbpa_pkg::ADDR_W-1:0]   result
);
  import fbpa_pkg::*;

  localparam int STEP_W = $clog2(ADDR_W);

  logic              active_r, active_nxt;
  logic              done_r, done_nxt;
  mdu_op_t           op_r, op_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] acc_r, acc_nxt;
  logic [ADDR_W-1:0] m_r, m_nxt;
  logic [ADDR_W-1:0] q_r, q_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;

  logic [SIZE_W:0]   rem_sh;
  logic [ADDR_W-1:0] add_a;
  logic [ADDR_W-1:0] add_b;
  logic [ADDR_W:0]   sum;

  // One adder serves both the shift-add multiply and the restoring divide.
  always_comb begin
    rem_sh = {rem_r, q_r[ADDR_W-1]};
    if (op_r == OP_MUL) begin
      add_a = acc_r;
      add_b = m_r;
    end else begin
      add_a = ADDR_W'(rem_sh);
      add_b = ~{{(ADDR_W - SIZE_W){1'b0}}, m_r[SIZE_W-1:0]};
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + (ADDR_W + 1)'(op_r == OP_DIV);
  end

  always_comb begin
    active_nxt = active_r;
    done_nxt = 1'b0;
    op_nxt = op_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    m_nxt = m_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    if (req.start) begin
      active_nxt = 1'b1;
      op_nxt = req.op;
      acc_nxt = opa;
      m_nxt = ADDR_W'(opb);
      rem_nxt = '0;
      if (req.op == OP_MUL) begin
        cnt_nxt = STEP_W'(IDX_W - 1);
        q_nxt = ADDR_W'(idx);
      end else begin
        cnt_nxt = STEP_W'(ADDR_W - 1);
        q_nxt = opa;
      end
    end else if (active_r) begin
      if (op_r == OP_MUL) begin
        if (q_r[0]) begin
          acc_nxt = sum[ADDR_W-1:0];
        end
        m_nxt = {m_r[ADDR_W-2:0], 1'b0};
        q_nxt = {1'b0, q_r[ADDR_W-1:1]};
      end else begin
        if (sum[ADDR_W]) begin
          rem_nxt = sum[SIZE_W-1:0];
        end else begin
          rem_nxt = rem_sh[SIZE_W-1:0];
        end
        q_nxt = {q_r[ADDR_W-2:0], sum[ADDR_W]};
      end
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == '0) begin
        active_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    m_r <= m_nxt;
    q_r <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign result = (op_r == OP_MUL) ? acc_r : q_r;

endmodule

// ===== hdl/fixed_block_pool_allocator.sv =====
// An accepted request is decoded first; clear, unused kinds and the full, empty and below-base
// errors give their result from decode, while an allocate multiplies and a free divides first.
// The shared serial multiply/divide unit handles one multiplier or quotient bit per cycle.
// A new request is taken in the cycle in which the previous result is shown.
// Synchronous active-low reset; the free stack reads as the identity order at once through
// per-entry valid bits, with no clearing pass. The receiver cannot stall results.
module fixed_block_pool_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_kind,
  input  logic [fbpa_pkg::ADDR_W-1:0]   in_free_address,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [fbpa_pkg::ADDR_W-1:0]   out_block_address,
  output logic [fbpa_pkg::IDX_W-1:0]    out_block_index,
  output logic [fbpa_pkg::CNT_W-1:0]    out_blocks_in_use,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [31:0]                   cfg_data
);
  import fbpa_pkg::*;

  state_t            state_r, state_nxt;
  logic [SIZE_W-1:0] block_size_r;
  logic [ADDR_W-1:0] pool_base_r;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [1:0]        kind_r;
  logic [ADDR_W-1:0] addr_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;

  logic [IDX_W-1:0]  stack_mem [CAPACITY];
  logic [IDX_W-1:0]  rd_data_r;
  logic [IDX_W-1:0]  rd_addr_r;
  logic              rd_valid_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [CNT_W-1:0]  used_dec;

  mdu_req_t          mdu_req;
  logic [ADDR_W-1:0] mdu_opa;
  logic [SIZE_W-1:0] size_eff;
  logic              mdu_done;
  logic [ADDR_W-1:0] mdu_result;

  logic              accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign rd_addr = used_r[IDX_W-1:0];
  assign used_dec = used_r - CNT_W'(1);
  assign size_eff = (block_size_r == '0) ? SIZE_W'(1) : block_size_r;

  fbpa_mdu u_mdu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mdu_req),
    .opa    (mdu_opa),
    .opb    (size_eff),
    .idx    (idx_nxt),
    .done   (mdu_done),
    .result (mdu_result)
  );

  always_comb begin
    state_nxt = state_r;
    used_nxt = used_r;
    valid_nxt = valid_r;
    idx_nxt = idx_r;
    out_valid_nxt = 1'b0;
    out_status_nxt = ST_OK;
    out_addr_nxt = '0;
    out_idx_nxt = '0;
    mdu_req.start = 1'b0;
    mdu_req.op = OP_MUL;
    mdu_opa = pool_base_r;
    mem_we = 1'b0;
    mem_wa = used_dec[IDX_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (kind_r)
          KIND_ALLOC: begin
            if (used_r >= CNT_W'(CAPACITY)) begin
              out_valid_nxt = 1'b1;
              out_status_nxt = ST_FULL;
              state_nxt = S_IDLE;
            end else begin
              idx_nxt = rd_valid_r ? rd_data_r : rd_addr_r;
              mdu_req.start = 1'b1;
              mdu_req.op = OP_MUL;
              mdu_opa = pool_base_r;
              state_nxt = S_MUL;
            end
          end
          KIND_FREE: begin
            if (used_r == '0) begin
              out_valid_nxt = 1'b1;
              out_status_nxt = ST_EMPTY;
              state_nxt = S_IDLE;
            end else if (addr_r < pool_base_r) begin
              out_valid_nxt = 1'b1;
              out_status_nxt = ST_BELOW;
              state_nxt = S_IDLE;
            end else begin
              mdu_req.start = 1'b1;
              mdu_req.op = OP_DIV;
              mdu_opa = addr_r - pool_base_r;
              state_nxt = S_DIV;
            end
          end
          KIND_CLEAR: begin
            valid_nxt = '0;
            used_nxt = '0;
            out_valid_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
          default: begin
            out_valid_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_MUL: begin
        if (mdu_done) begin
          used_nxt = used_r + CNT_W'(1);
          out_valid_nxt = 1'b1;
          out_addr_nxt = mdu_result;
          out_idx_nxt = idx_r;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (mdu_done) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
          if (mdu_result >= ADDR_W'(CAPACITY)) begin
            out_status_nxt = ST_BEYOND;
          end else begin
            used_nxt = used_dec;
            mem_we = 1'b1;
            valid_nxt[mem_wa] = 1'b1;
            out_idx_nxt = mdu_result[IDX_W-1:0];
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r <= '0;
      valid_r <= '0;
      out_valid_r <= 1'b0;
      block_size_r <= SIZE_W'(64);
      pool_base_r <= '0;
    end else begin
      state_r <= state_nxt;
      used_r <= used_nxt;
      valid_r <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_BLOCK_SIZE: block_size_r <= cfg_data[SIZE_W-1:0];
          CFG_POOL_BASE:  pool_base_r <= cfg_data[ADDR_W-1:0];
          default:        pool_base_r <= pool_base_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      addr_r <= in_free_address;
    end
    idx_r <= idx_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r <= out_addr_nxt;
    out_idx_r <= out_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_wa] <= mdu_result[IDX_W-1:0];
    end
    rd_data_r <= stack_mem[rd_addr];
    rd_addr_r <= rd_addr;
    rd_valid_r <= valid_r[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_block_address = out_addr_r;
  assign out_block_index = out_idx_r;
  assign out_blocks_in_use = used_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(CAPACITY))
    else $error("In-use count exceeds the pool capacity.");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("Accepted request did not make the block busy.");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_block_address == '0) && (out_block_index == '0))
    else $error("Error result carries a nonzero address or index.");

  a_error_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_nxt && (out_status_nxt != ST_OK) |=> $stable(used_r))
    else $error("Error result changed the in-use count.");

  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mdu_done |-> (state_r == S_MUL) || (state_r == S_DIV))
    else $error("Arithmetic unit finished outside a multiply or divide step.");

endmodule
